>>> rtl/assert_macros.svh
// Assertion macros of the countdown timer RTL, used by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent at one edge implies the consequent at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cdt_pkg.sv
// Types, codes and segment table of the countdown timer
package cdt_pkg;

    // Operating mode
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_ALARM = 2'd2
    } mode_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_IDX_TICKS_PER_SECOND = 2'd0;
    localparam logic [1:0] CFG_IDX_BEEP_ON_TICKS    = 2'd1;
    localparam logic [1:0] CFG_IDX_ALARM_SECONDS    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd50;
    localparam logic [7:0] BEEP_ON_TICKS_RST    = 8'd10;
    localparam logic [3:0] ALARM_SECONDS_RST    = 4'd5;

    // Time limits
    localparam logic [5:0] SEC_MAX      = 6'd59;
    localparam logic [6:0] MIN_MAX      = 7'd59;
    localparam logic [6:0] MIN_WRAP     = 7'd60;
    localparam logic [6:0] HOUR_WRAP    = 7'd99;
    localparam logic [6:0] MIN_STEP_TEN = 7'd10;

    // Reciprocal of ten for a 7-bit value: tens = (v * 205) >> 11
    localparam logic [7:0] RECIP_TEN       = 8'd205;
    localparam int         RECIP_TEN_SHIFT = 11;

    typedef struct packed {
        logic [7:0] ticks_per_second;
        logic [7:0] beep_on_ticks;
        logic [3:0] alarm_seconds;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic one_minute;
        logic ten_minutes;
        logic one_hour;
        logic start;
    } item_t;

    // Updated state that a result shows
    typedef struct packed {
        logic [6:0] hours;
        logic [6:0] minutes;
        logic [5:0] seconds;
        logic       dot;
        logic       beep;
        mode_t      mode;
    } view_t;

    typedef struct packed {
        logic [7:0] left_tens;
        logic [7:0] left_units;
        logic [7:0] right_tens;
        logic [7:0] right_units;
    } seg_t;

    // Active-low seven-segment code of one decimal digit
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = 8'hFF;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/cdt_cfg.sv
// Configuration register file of the countdown timer
module cdt_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    output cdt_pkg::cfg_t cfg
);

    cdt_pkg::cfg_t cfg_reg;
    cdt_pkg::cfg_t cfg_next;

    // Decode the write transfer
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                cdt_pkg::CFG_IDX_TICKS_PER_SECOND: cfg_next.ticks_per_second = cfg_data;
                cdt_pkg::CFG_IDX_BEEP_ON_TICKS:    cfg_next.beep_on_ticks    = cfg_data;
                cdt_pkg::CFG_IDX_ALARM_SECONDS:    cfg_next.alarm_seconds    = cfg_data[3:0];
                default:                           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_second <= cdt_pkg::TICKS_PER_SECOND_RST;
            cfg_reg.beep_on_ticks    <= cdt_pkg::BEEP_ON_TICKS_RST;
            cfg_reg.alarm_seconds    <= cdt_pkg::ALARM_SECONDS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/cdt_core.sv
// Timer state registers and the per-item update logic
`include "assert_macros.svh"

module cdt_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  cdt_pkg::item_t item,
    input  cdt_pkg::cfg_t  cfg,
    output cdt_pkg::view_t view
);

    logic [6:0]      hours_reg, hours_next;
    logic [6:0]      minutes_reg, minutes_next;
    logic [5:0]      seconds_reg, seconds_next;
    logic [7:0]      second_ticks_reg, second_ticks_next;
    logic [7:0]      alarm_ticks_reg, alarm_ticks_next;
    logic [3:0]      alarm_count_reg, alarm_count_next;
    cdt_pkg::mode_t  mode_reg, mode_next;
    logic            lock_reg, lock_next;
    logic            dot_reg, dot_next;
    logic            beep_reg, beep_next;

    logic [7:0]      st_inc;
    logic [7:0]      at_inc;
    logic [3:0]      ac_inc;
    logic            any_press;
    logic            time_nonzero;

    assign st_inc       = second_ticks_reg + 8'd1;
    assign at_inc       = alarm_ticks_reg + 8'd1;
    assign ac_inc       = alarm_count_reg + 4'd1;
    assign any_press    = item.one_minute | item.ten_minutes | item.one_hour | item.start;
    assign time_nonzero = (hours_reg != 7'd0) || (minutes_reg != 7'd0) || (seconds_reg != 6'd0);

    // Next state for one item, then normalize the time
    always_comb
    begin
        hours_next        = hours_reg;
        minutes_next      = minutes_reg;
        seconds_next      = seconds_reg;
        second_ticks_next = second_ticks_reg;
        alarm_ticks_next  = alarm_ticks_reg;
        alarm_count_next  = alarm_count_reg;
        mode_next         = mode_reg;
        lock_next         = lock_reg;
        dot_next          = dot_reg;
        beep_next         = beep_reg;

        case (mode_reg)
            cdt_pkg::MODE_RUN:
            begin
                if (item.tick)
                begin
                    second_ticks_next = st_inc;
                    if (st_inc >= cfg.ticks_per_second)
                    begin
                        second_ticks_next = 8'd0;
                        dot_next          = ~dot_reg;
                        // Count H:MM:SS down by one second
                        if (seconds_reg == 6'd0)
                        begin
                            seconds_next = cdt_pkg::SEC_MAX;
                            if (minutes_reg == 7'd0)
                            begin
                                if (hours_reg != 7'd0)
                                begin
                                    hours_next   = hours_reg - 7'd1;
                                    minutes_next = cdt_pkg::MIN_MAX;
                                end
                                else
                                begin
                                    hours_next       = 7'd0;
                                    minutes_next     = 7'd0;
                                    seconds_next     = 6'd0;
                                    mode_next        = cdt_pkg::MODE_ALARM;
                                    alarm_ticks_next = 8'd0;
                                    alarm_count_next = 4'd0;
                                end
                            end
                            else
                            begin
                                minutes_next = minutes_reg - 7'd1;
                            end
                        end
                        else
                        begin
                            seconds_next = seconds_reg - 6'd1;
                        end
                    end
                end
            end
            cdt_pkg::MODE_ALARM:
            begin
                if (item.tick)
                begin
                    alarm_ticks_next = at_inc;
                    if (at_inc >= cfg.ticks_per_second)
                    begin
                        // Second boundary: beeper keeps its level here unless the alarm ends
                        alarm_ticks_next = 8'd0;
                        dot_next         = ~dot_reg;
                        alarm_count_next = ac_inc;
                        if (ac_inc >= cfg.alarm_seconds)
                        begin
                            hours_next       = 7'd0;
                            minutes_next     = 7'd0;
                            seconds_next     = 6'd0;
                            alarm_count_next = 4'd0;
                            beep_next        = 1'b0;
                            mode_next        = cdt_pkg::MODE_IDLE;
                        end
                    end
                    else
                    begin
                        beep_next = (at_inc < cfg.beep_on_ticks);
                    end
                end
            end
            default:
            begin
                // Idle: one action per press, in button priority order
                if (!lock_reg && any_press)
                begin
                    lock_next = 1'b1;
                    if (item.one_minute)
                    begin
                        minutes_next = minutes_reg + 7'd1;
                    end
                    else if (item.ten_minutes)
                    begin
                        minutes_next = minutes_reg + cdt_pkg::MIN_STEP_TEN;
                    end
                    else if (item.one_hour)
                    begin
                        hours_next = hours_reg + 7'd1;
                    end
                    else if (time_nonzero)
                    begin
                        mode_next         = cdt_pkg::MODE_RUN;
                        second_ticks_next = 8'd0;
                    end
                end
                else if (!any_press)
                begin
                    lock_next = 1'b0;
                end
            end
        endcase

        // Normalize: minute carry, then hour overflow clears the time
        if (minutes_next >= cdt_pkg::MIN_WRAP)
        begin
            minutes_next = 7'd0;
            hours_next   = hours_next + 7'd1;
        end
        if (hours_next >= cdt_pkg::HOUR_WRAP)
        begin
            hours_next   = 7'd0;
            minutes_next = 7'd0;
            seconds_next = 6'd0;
        end
    end

    // Hold state until an item advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hours_reg        <= 7'd0;
            minutes_reg      <= 7'd0;
            seconds_reg      <= 6'd0;
            second_ticks_reg <= 8'd0;
            alarm_ticks_reg  <= 8'd0;
            alarm_count_reg  <= 4'd0;
            mode_reg         <= cdt_pkg::MODE_IDLE;
            lock_reg         <= 1'b0;
            dot_reg          <= 1'b0;
            beep_reg         <= 1'b0;
        end
        else if (advance)
        begin
            hours_reg        <= hours_next;
            minutes_reg      <= minutes_next;
            seconds_reg      <= seconds_next;
            second_ticks_reg <= second_ticks_next;
            alarm_ticks_reg  <= alarm_ticks_next;
            alarm_count_reg  <= alarm_count_next;
            mode_reg         <= mode_next;
            lock_reg         <= lock_next;
            dot_reg          <= dot_next;
            beep_reg         <= beep_next;
        end
    end

    assign view.hours   = hours_next;
    assign view.minutes = minutes_next;
    assign view.seconds = seconds_next;
    assign view.dot     = dot_next;
    assign view.beep    = beep_next;
    assign view.mode    = mode_next;

    // Checks
    `ASSERT_ALWAYS(a_time_range,
        (hours_reg < cdt_pkg::HOUR_WRAP) && (minutes_reg < cdt_pkg::MIN_WRAP) &&
        (seconds_reg <= cdt_pkg::SEC_MAX),
        "time state out of normalized range")
    `ASSERT_ALWAYS(a_beep_in_alarm, !beep_reg || (mode_reg == cdt_pkg::MODE_ALARM),
        "beeper on outside alarm")
    `ASSERT_NEXT(a_hold_when_stalled, !advance,
        $stable(hours_reg) && $stable(minutes_reg) && $stable(seconds_reg) &&
        $stable(mode_reg) && $stable(lock_reg),
        "state changed without an item")

endmodule

>>> rtl/cdt_disp.sv
// Digit split and seven-segment encoding of the displayed time
module cdt_disp (
    input  cdt_pkg::view_t view,
    output cdt_pkg::seg_t  seg
);

    logic [6:0]  left_val;
    logic [6:0]  right_val;
    logic [14:0] left_prod;
    logic [14:0] right_prod;
    logic [3:0]  left_tens;
    logic [3:0]  right_tens;
    logic [3:0]  left_units;
    logic [3:0]  right_units;

    // Pick HH MM while hours run, else MM SS
    always_comb
    begin
        if (view.hours != 7'd0)
        begin
            left_val  = view.hours;
            right_val = view.minutes;
        end
        else
        begin
            left_val  = view.minutes;
            right_val = {1'b0, view.seconds};
        end
    end

    // Divide by ten through the reciprocal, units by subtraction
    assign left_prod   = 15'(left_val) * 15'(cdt_pkg::RECIP_TEN);
    assign right_prod  = 15'(right_val) * 15'(cdt_pkg::RECIP_TEN);
    assign left_tens   = 4'(left_prod >> cdt_pkg::RECIP_TEN_SHIFT);
    assign right_tens  = 4'(right_prod >> cdt_pkg::RECIP_TEN_SHIFT);
    assign left_units  = 4'(left_val - 7'(left_tens) * 7'd10);
    assign right_units = 4'(right_val - 7'(right_tens) * 7'd10);

    assign seg.left_tens   = cdt_pkg::seg_code(left_tens);
    assign seg.left_units  = cdt_pkg::seg_code(left_units);
    assign seg.right_tens  = cdt_pkg::seg_code(right_tens);
    assign seg.right_units = cdt_pkg::seg_code(right_units);

endmodule

>>> rtl/countdown_timer_with_alarm_unit.sv
// Top level of the countdown timer: input register, update logic, result register
//
//   Channel  Direction  Handshake                  Carries
//   in       sink       in_valid / in_ready        tick and four button levels
//   out      source     out_valid / out_ready      four segment codes, dot, beeper, mode
//   cfg      sink       cfg_valid / cfg_ready      register index and write data
//
// An item waits in the input register; the state update and the segment encoding
// run in the cycle it moves into the result register. Sustained rate is one item
// per cycle while out_ready holds; an item passes the input register and then the
// result register before out_valid. A stalled result register holds the input
// register, which still takes one more item. Reset clears the time, all counters
// and the configuration to its defaults; the configuration port is always ready.
module countdown_timer_with_alarm_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       tick,
    input  logic       press_one_minute,
    input  logic       press_ten_minutes,
    input  logic       press_one_hour,
    input  logic       press_start,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] seg_left_tens,
    output logic [7:0] seg_left_units,
    output logic [7:0] seg_right_tens,
    output logic [7:0] seg_right_units,
    output logic       dot_lamp,
    output logic       beeper,
    output logic [1:0] mode_now,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cdt_pkg::cfg_t  cfg;
    cdt_pkg::view_t view;
    cdt_pkg::seg_t  seg;

    logic           in_valid_reg;
    cdt_pkg::item_t item_reg;
    logic           out_valid_reg;
    cdt_pkg::seg_t  seg_reg;
    logic           dot_reg;
    logic           beep_reg;
    cdt_pkg::mode_t mode_reg;
    logic           advance;

    // Move an item on when the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    cdt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cdt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .view    (view)
    );

    cdt_disp u_disp (
        .view (view),
        .seg  (seg)
    );

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Capture the item on an input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.tick        <= tick;
            item_reg.one_minute  <= press_one_minute;
            item_reg.ten_minutes <= press_ten_minutes;
            item_reg.one_hour    <= press_one_hour;
            item_reg.start       <= press_start;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            seg_reg  <= seg;
            dot_reg  <= view.dot;
            beep_reg <= view.beep;
            mode_reg <= view.mode;
        end
    end

    assign out_valid       = out_valid_reg;
    assign seg_left_tens   = seg_reg.left_tens;
    assign seg_left_units  = seg_reg.left_units;
    assign seg_right_tens  = seg_reg.right_tens;
    assign seg_right_units = seg_reg.right_units;
    assign dot_lamp        = dot_reg;
    assign beeper          = beep_reg;
    assign mode_now        = mode_reg;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the countdown timer with alarm
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cdt_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int MAX_REPORTS     = 10;
    localparam int RUN_GUARD_ITEMS = 4000;
    localparam longint RUN_LIMIT_NS = 4_000_000;

    // Active-low digit codes, digit 0 in the low byte
    localparam logic [79:0] DIGIT_CODES = {
        8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };

    // What one result shows on the front panel
    typedef struct packed {
        logic [7:0] left_tens;
        logic [7:0] left_units;
        logic [7:0] right_tens;
        logic [7:0] right_units;
        logic       dot;
        logic       beep;
        logic [1:0] mode;
    } face_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       tick = 1'b0;
    logic       press_one_minute = 1'b0;
    logic       press_ten_minutes = 1'b0;
    logic       press_one_hour = 1'b0;
    logic       press_start = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] seg_left_tens;
    logic [7:0] seg_left_units;
    logic [7:0] seg_right_tens;
    logic [7:0] seg_right_units;
    logic       dot_lamp;
    logic       beeper;
    logic [1:0] mode_now;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    countdown_timer_with_alarm_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .tick              (tick),
        .press_one_minute  (press_one_minute),
        .press_ten_minutes (press_ten_minutes),
        .press_one_hour    (press_one_hour),
        .press_start       (press_start),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .seg_left_tens     (seg_left_tens),
        .seg_left_units    (seg_left_units),
        .seg_right_tens    (seg_right_tens),
        .seg_right_units   (seg_right_units),
        .dot_lamp          (dot_lamp),
        .beeper            (beeper),
        .mode_now          (mode_now),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // Clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Timer state as the testbench tracks it
    logic [6:0] t_hours = '0;
    logic [6:0] t_minutes = '0;
    logic [5:0] t_seconds = '0;
    logic [7:0] t_sec_ticks = '0;
    logic [7:0] t_alarm_ticks = '0;
    logic [3:0] t_alarm_count = '0;
    mode_t      t_mode = MODE_IDLE;
    logic       t_lock = 1'b0;
    logic       t_dot = 1'b0;
    logic       t_beep = 1'b0;

    // Register settings as the testbench tracks them
    logic [7:0] set_tps = TICKS_PER_SECOND_RST;
    logic [7:0] set_beep_on = BEEP_ON_TICKS_RST;
    logic [3:0] set_alarm_secs = ALARM_SECONDS_RST;

    face_t expected_faces[$];
    int    failures = 0;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    logic  holding = 1'b0;
    event  hold_off_start;

    function automatic logic [7:0] digit_code(input int digit);
        return DIGIT_CODES[digit * 8 +: 8];
    endfunction

    function automatic string face_text(input face_t f);
        return $sformatf("segs %h %h %h %h dot %b beep %b mode %0d", f.left_tens,
                         f.left_units, f.right_tens, f.right_units, f.dot, f.beep, f.mode);
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("[%0t] %s", $time, msg);
    endfunction

    // Advance the tracked timer by one sample period and return the panel it shows
    function automatic face_t timer_step(input item_t it);
        face_t f;
        int    left;
        int    right;
        case (t_mode)
            MODE_RUN:
            begin
                if (it.tick)
                begin
                    t_sec_ticks = t_sec_ticks + 8'd1;
                    if (t_sec_ticks >= set_tps)
                    begin
                        t_sec_ticks = '0;
                        t_dot = ~t_dot;
                        // Count H:MM:SS down, alarm once it passes zero
                        if (t_seconds != 0)
                            t_seconds = t_seconds - 6'd1;
                        else
                        begin
                            t_seconds = SEC_MAX;
                            if (t_minutes != 0)
                                t_minutes = t_minutes - 7'd1;
                            else if (t_hours != 0)
                            begin
                                t_hours = t_hours - 7'd1;
                                t_minutes = MIN_MAX;
                            end
                            else
                            begin
                                t_seconds = '0;
                                t_mode = MODE_ALARM;
                                t_alarm_ticks = '0;
                                t_alarm_count = '0;
                            end
                        end
                    end
                end
            end
            MODE_ALARM:
            begin
                if (it.tick)
                begin
                    t_alarm_ticks = t_alarm_ticks + 8'd1;
                    if (t_alarm_ticks >= set_tps)
                    begin
                        // Second boundary wins over the beep test
                        t_alarm_ticks = '0;
                        t_dot = ~t_dot;
                        t_alarm_count = t_alarm_count + 4'd1;
                        if (t_alarm_count >= set_alarm_secs)
                        begin
                            t_hours = '0;
                            t_minutes = '0;
                            t_seconds = '0;
                            t_alarm_count = '0;
                            t_beep = 1'b0;
                            t_mode = MODE_IDLE;
                        end
                    end
                    else
                        t_beep = (t_alarm_ticks < set_beep_on);
                end
            end
            default:
            begin
                // One action per press, in button priority order
                if (!t_lock && (it.one_minute || it.ten_minutes || it.one_hour || it.start))
                begin
                    t_lock = 1'b1;
                    if (it.one_minute)
                        t_minutes = t_minutes + 7'd1;
                    else if (it.ten_minutes)
                        t_minutes = t_minutes + MIN_STEP_TEN;
                    else if (it.one_hour)
                        t_hours = t_hours + 7'd1;
                    else if (t_hours != 0 || t_minutes != 0 || t_seconds != 0)
                    begin
                        t_mode = MODE_RUN;
                        t_sec_ticks = '0;
                    end
                end
                else if (!(it.one_minute || it.ten_minutes || it.one_hour || it.start))
                    t_lock = 1'b0;
            end
        endcase

        // Normalize the time
        if (t_minutes >= MIN_WRAP)
        begin
            t_minutes = '0;
            t_hours = t_hours + 7'd1;
        end
        if (t_hours >= HOUR_WRAP)
        begin
            t_hours = '0;
            t_minutes = '0;
            t_seconds = '0;
        end

        left = (t_hours != 0) ? int'(t_hours) : int'(t_minutes);
        right = (t_hours != 0) ? int'(t_minutes) : int'(t_seconds);
        f.left_tens = digit_code((left / 10) % 10);
        f.left_units = digit_code(left % 10);
        f.right_tens = digit_code((right / 10) % 10);
        f.right_units = digit_code(right % 10);
        f.dot = t_dot;
        f.beep = t_beep;
        f.mode = t_mode;
        return f;
    endfunction

    // Predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin : check_results
        face_t got;
        face_t want;
        item_t taken;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                taken = {tick, press_one_minute, press_ten_minutes, press_one_hour,
                         press_start};
                expected_faces.push_back(timer_step(taken));
            end
            if (out_valid && out_ready)
            begin
                got = {seg_left_tens, seg_left_units, seg_right_tens, seg_right_units,
                       dot_lamp, beeper, mode_now};
                if (expected_faces.size() == 0)
                    note_failure($sformatf("result with nothing expected: %s",
                                           face_text(got)));
                else
                begin
                    want = expected_faces.pop_front();
                    if (got !== want)
                        note_failure($sformatf("mismatch: expected %s, got %s",
                                               face_text(want), face_text(got)));
                end
            end
        end
    end

    // Long receiver hold-off, counted in cycles
    always
    begin
        @(hold_off_start);
        holding = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    // Receiver: stall at random unless held off
    always @(negedge clk)
        out_ready <= !holding && ($urandom_range(99) >= stall_pct);

    // Offer one sample period and hold it until the transfer
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        tick = it.tick;
        press_one_minute = it.one_minute;
        press_ten_minutes = it.ten_minutes;
        press_one_hour = it.one_hour;
        press_start = it.start;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Press a button pattern, sometimes let go in two steps, then release all
    task automatic press(input item_t held);
        item_t rel;
        send_item(held);
        if ($urandom_range(99) < 15)
        begin
            rel = '0;
            rel[3:0] = 4'b0001 << $urandom_range(3);
            rel.tick = 1'($urandom_range(1));
            send_item(rel);
        end
        rel = '0;
        rel.tick = 1'($urandom_range(1));
        send_item(rel);
    endtask

    function automatic item_t minute_press();
        item_t it;
        it = item_t'($urandom_range(31));
        it.one_minute = 1'b1;
        return it;
    endfunction

    // Stop offering and wait for every result to come back
    task automatic drain_results();
        in_valid = 1'b0;
        while (expected_faces.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_IDX_TICKS_PER_SECOND: set_tps = data;
            CFG_IDX_BEEP_ON_TICKS:    set_beep_on = data;
            CFG_IDX_ALARM_SECONDS:    set_alarm_secs = data[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [7:0] tps, input logic [7:0] beep_on,
                             input logic [3:0] alarm_secs);
        drain_results();
        write_register(CFG_IDX_TICKS_PER_SECOND, tps);
        write_register(CFG_IDX_BEEP_ON_TICKS, beep_on);
        // Upper bits of the alarm length are dont-care
        write_register(CFG_IDX_ALARM_SECONDS, {4'($urandom_range(15)), alarm_secs});
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        @(posedge clk);
        send_idle_pct = sender_pct;
        stall_pct = receiver_pct;
        @(negedge clk);
    endtask

    // Buttons, priority, press lock and start with zero time
    task automatic test_buttons();
        set_idling(0, 0);
        send_item(5'b10000);
        send_item(5'b10001);
        send_item(5'b01001);
        send_item(5'b10000);
        send_item(5'b11111);
        send_item(5'b11111);
        send_item(5'b00000);
        send_item(5'b00111);
        send_item(5'b10000);
        send_item(5'b10011);
        send_item(5'b00001);
        send_item(5'b01000);
        send_item(5'b00000);
    endtask

    // Minute carry into the hour and hour overflow that clears the time
    task automatic test_time_wrap();
        item_t it;
        configure(8'd255, 8'd1, 4'd15);
        set_idling(57, 0);
        while (t_minutes < 7'd50)
        begin
            it = item_t'($urandom_range(31));
            it.one_minute = 1'b0;
            it.ten_minutes = 1'b1;
            press(it);
        end
        do
            press(minute_press());
        while (t_minutes != 0);
        while (t_hours != 0)
        begin
            it = item_t'($urandom_range(31));
            it.one_minute = 1'b0;
            it.ten_minutes = 1'b0;
            it.one_hour = 1'b1;
            press(it);
        end
    endtask

    // Set a short time, start, and run through the countdown and the alarm
    task automatic test_countdown(input logic [7:0] tps, input logic [7:0] beep_on,
                                  input logic [3:0] alarm_secs, input int sender_pct,
                                  input int receiver_pct, input int tick_pct,
                                  input bit hold_off);
        item_t it;
        int    guard;
        configure(tps, beep_on, alarm_secs);
        set_idling(sender_pct, receiver_pct);
        press(minute_press());
        if (hold_off)
        begin
            @(posedge clk);
            -> hold_off_start;
            @(negedge clk);
        end
        // Start with a tick: the tick must not count
        send_item(5'b10001);
        guard = 0;
        while (t_mode != MODE_IDLE && guard < RUN_GUARD_ITEMS)
        begin
            it = item_t'($urandom_range(31));
            it.tick = ($urandom_range(99) < tick_pct);
            send_item(it);
            guard++;
        end
        send_item({1'($urandom_range(1)), 4'b0000});
    endtask

    // Hour borrow: 1:00:00 counts down through 0:59:59 to 0:59:57
    task automatic test_hour_borrow();
        configure(8'd2, 8'd10, 4'd5);
        set_idling(13, 13);
        press(5'b00010);
        send_item(5'b00001);
        while (t_hours != 0 || t_seconds > 6'd57)
            send_item(5'b10000);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_buttons();
        test_time_wrap();
        test_countdown(8'd1, 8'd1, 4'd0, 0, 0, 100, 1'b0);
        test_countdown(8'd2, 8'd255, 4'd15, 57, 0, 90, 1'b0);
        test_countdown(8'd3, 8'd2, 4'd1, 0, 57, 85, 1'b1);
        test_countdown(8'd0, 8'd200, 4'd3, 13, 13, 95, 1'b0);
        test_hour_borrow();

        drain_results();
        if (expected_faces.size() != 0)
            note_failure("results still expected at the end");
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #RUN_LIMIT_NS;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> countdown_timer_with_alarm_unit.f
+incdir+rtl
rtl/cdt_pkg.sv
rtl/cdt_cfg.sv
rtl/cdt_core.sv
rtl/cdt_disp.sv
rtl/countdown_timer_with_alarm_unit.sv
tb/tb_top.sv
